// ===== rtl/ffba_pkg.sv =====
// ffba_pkg: shared types, constants and helpers for the first-fit block allocator
// no dependencies; imported by ffba_seq and first_fit_block_allocator_core
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;

  localparam logic [31:0] MAX_REQUEST    = 32'h0080_0000;
  localparam logic [31:0] ROUND_ADD      = 32'd15;
  localparam logic [31:0] ROUND_MASK     = 32'hffff_fff0;
  localparam logic [31:0] MIN_SIZE       = 32'd4;
  localparam logic [31:0] HEAP_START_RST = 32'd1;
  localparam logic [31:0] HEAP_TOP_RST   = 32'd0;

  localparam logic [2:0] FN_ALLOC   = 3'd0;
  localparam logic [2:0] FN_FREE    = 3'd1;
  localparam logic [2:0] FN_REALLOC = 3'd2;
  localparam logic [2:0] FN_SIZE    = 3'd3;
  localparam logic [2:0] FN_IMPORT  = 3'd4;

  localparam logic REG_HEAP_START = 1'b0;
  localparam logic REG_HEAP_TOP   = 1'b1;

  typedef struct packed {
    logic        used;
    logic [31:0] size;
    logic [31:0] addr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        mark_used;
    logic [31:0] amount;
    logic [31:0] address;
    logic [2:0]  func;
  } req_t;

  typedef struct packed {
    logic [31:0] copy_bytes;
    logic [31:0] copy_from;
    logic [31:0] result;
  } rsp_t;

  typedef struct packed {
    logic        start_wr;
    logic [31:0] start_val;
    logic [31:0] limit;
  } cfg_t;

  // at least four bytes, then up to a multiple of 16
  function automatic logic [31:0] round_size(input logic [31:0] req);
    logic [31:0] s;
    s = (req < MIN_SIZE) ? MIN_SIZE : req;
    return (s + ROUND_ADD) & ROUND_MASK;
  endfunction

endpackage

// ===== rtl/ffba_ram.sv =====
// ffba_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 65,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ffba_seq.sv =====
// ffba_seq: sequencer that walks the block table (search, shift, sort, merge)
// depends on ffba_pkg and ffba_ram
`timescale 1ns / 1ps

module ffba_seq
  import ffba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_FIND_RD   = 4'd1;
  localparam logic [3:0] ST_FIND_EV   = 4'd2;
  localparam logic [3:0] ST_SHIFT_RD  = 4'd3;
  localparam logic [3:0] ST_SHIFT_EV  = 4'd4;
  localparam logic [3:0] ST_SPLIT_LO  = 4'd5;
  localparam logic [3:0] ST_SPLIT_HI  = 4'd6;
  localparam logic [3:0] ST_SORT_RD   = 4'd7;
  localparam logic [3:0] ST_SORT_HOLD = 4'd8;
  localparam logic [3:0] ST_SORT_CRD  = 4'd9;
  localparam logic [3:0] ST_SORT_CMP  = 4'd10;
  localparam logic [3:0] ST_MERGE_RD  = 4'd11;
  localparam logic [3:0] ST_MERGE_EV  = 4'd12;
  localparam logic [3:0] ST_MERGE_END = 4'd13;
  localparam logic [3:0] ST_ALLOC_END = 4'd14;
  localparam logic [3:0] ST_OUT       = 4'd15;

  localparam logic [1:0] MD_SIZE  = 2'd0;
  localparam logic [1:0] MD_FREE  = 2'd1;
  localparam logic [1:0] MD_ALLOC = 2'd2;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic             realloc_r, realloc_nxt;
  logic             merge_after_r, merge_after_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [31:0]      amt_r, amt_nxt;
  logic [31:0]      old_r, old_nxt;
  logic [31:0]      result_r, result_nxt;
  logic [31:0]      cfrom_r, cfrom_nxt;
  logic [31:0]      cbytes_r, cbytes_nxt;
  logic [31:0]      bump_r, bump_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  entry_t           hold_r, hold_nxt;
  entry_t           prev_r, prev_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;
  entry_t           e;

  logic [31:0]      size_w;
  logic [31:0]      cb_w;
  logic [CNT_W-1:0] i_inc, j_dec, n_dec;
  logic             size_done;
  logic [31:0]      size_val;

  ffba_ram #(
    .DEPTH(TABLE_ENTRIES),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign e      = entry_t'(rdata);
  assign size_w = round_size(amt_r);
  assign cb_w   = (old_r < amt_r) ? old_r : amt_r;
  assign i_inc  = i_r + CNT_ONE;
  assign j_dec  = j_r - CNT_ONE;
  assign n_dec  = n_r - CNT_ONE;

  assign req_ready = (state_r == ST_IDLE);
  assign rsp_valid = (state_r == ST_OUT);
  assign rsp       = '{copy_bytes: cbytes_r, copy_from: cfrom_r, result: result_r};

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    realloc_nxt     = realloc_r;
    merge_after_nxt = merge_after_r;
    addr_nxt        = addr_r;
    amt_nxt         = amt_r;
    old_nxt         = old_r;
    result_nxt      = result_r;
    cfrom_nxt       = cfrom_r;
    cbytes_nxt      = cbytes_r;
    bump_nxt        = bump_r;
    cnt_nxt         = cnt_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    n_nxt           = n_r;
    hold_nxt        = hold_r;
    prev_nxt        = prev_r;
    we              = 1'b0;
    waddr           = '0;
    wdata           = '0;
    raddr           = '0;
    size_done       = 1'b0;
    size_val        = '0;

    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          addr_nxt    = req.address;
          amt_nxt     = req.amount;
          result_nxt  = '0;
          cfrom_nxt   = '0;
          cbytes_nxt  = '0;
          realloc_nxt = 1'b0;
          i_nxt       = '0;
          case (req.func)
            FN_ALLOC: begin
              if (req.amount > MAX_REQUEST) begin
                state_nxt = ST_ALLOC_END;
              end else begin
                mode_nxt  = MD_ALLOC;
                state_nxt = ST_FIND_RD;
              end
            end
            FN_FREE: begin
              mode_nxt  = MD_FREE;
              state_nxt = ST_FIND_RD;
            end
            FN_REALLOC: begin
              mode_nxt    = MD_SIZE;
              realloc_nxt = 1'b1;
              state_nxt   = ST_FIND_RD;
            end
            FN_SIZE: begin
              mode_nxt  = MD_SIZE;
              state_nxt = ST_FIND_RD;
            end
            FN_IMPORT: begin
              if (req.address == '0 || req.amount == '0 || cnt_r == CNT_FULL) begin
                state_nxt = ST_OUT;
              end else begin
                we              = 1'b1;
                waddr           = cnt_r[IDX_W-1:0];
                wdata           = '{used: req.mark_used, size: req.amount, addr: req.address};
                cnt_nxt         = cnt_r + CNT_ONE;
                result_nxt      = 32'd1;
                merge_after_nxt = 1'b1;
                i_nxt           = CNT_ONE;
                state_nxt       = ST_SORT_RD;
              end
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end

      ST_FIND_RD: begin
        if (i_r == cnt_r) begin
          // walked off the end of the table
          case (mode_r)
            MD_SIZE: begin
              size_done = 1'b1;
              size_val  = '0;
            end
            MD_ALLOC: begin
              state_nxt = ST_ALLOC_END;
              if (!(bump_r > cfg.limit) && !(size_w > cfg.limit - bump_r) &&
                  bump_r != '0 && cnt_r != CNT_FULL) begin
                we              = 1'b1;
                waddr           = cnt_r[IDX_W-1:0];
                wdata           = '{used: 1'b1, size: size_w, addr: bump_r};
                cnt_nxt         = cnt_r + CNT_ONE;
                result_nxt      = bump_r;
                bump_nxt        = bump_r + size_w;
                merge_after_nxt = 1'b0;
                i_nxt           = CNT_ONE;
                state_nxt       = ST_SORT_RD;
              end
            end
            default: state_nxt = ST_OUT;
          endcase
        end else begin
          raddr     = i_r[IDX_W-1:0];
          state_nxt = ST_FIND_EV;
        end
      end

      ST_FIND_EV: begin
        i_nxt     = i_inc;
        state_nxt = ST_FIND_RD;
        case (mode_r)
          MD_SIZE: begin
            if (e.used && e.addr == addr_r) begin
              size_done = 1'b1;
              size_val  = e.size;
            end
          end
          MD_FREE: begin
            if (e.used && e.addr == addr_r) begin
              we              = 1'b1;
              waddr           = i_r[IDX_W-1:0];
              wdata           = '{used: 1'b0, size: e.size, addr: e.addr};
              merge_after_nxt = 1'b1;
              i_nxt           = CNT_ONE;
              state_nxt       = ST_SORT_RD;
            end
          end
          MD_ALLOC: begin
            if (!e.used && !(e.size < size_w)) begin
              result_nxt = e.addr;
              i_nxt      = i_r;
              if (e.size == size_w) begin
                we        = 1'b1;
                waddr     = i_r[IDX_W-1:0];
                wdata     = '{used: 1'b1, size: e.size, addr: e.addr};
                state_nxt = ST_ALLOC_END;
              end else if (cnt_r == CNT_FULL) begin
                result_nxt = '0;
                state_nxt  = ST_ALLOC_END;
              end else begin
                // open a slot right after the chosen block
                hold_nxt  = e;
                j_nxt     = cnt_r;
                state_nxt = ST_SHIFT_RD;
              end
            end
          end
          default: state_nxt = ST_OUT;
        endcase
      end

      ST_SHIFT_RD: begin
        if (j_r == i_inc) begin
          state_nxt = ST_SPLIT_LO;
        end else begin
          raddr     = j_dec[IDX_W-1:0];
          state_nxt = ST_SHIFT_EV;
        end
      end

      ST_SHIFT_EV: begin
        we        = 1'b1;
        waddr     = j_r[IDX_W-1:0];
        wdata     = e;
        j_nxt     = j_dec;
        state_nxt = ST_SHIFT_RD;
      end

      ST_SPLIT_LO: begin
        we        = 1'b1;
        waddr     = i_inc[IDX_W-1:0];
        wdata     = '{used: 1'b0, size: hold_r.size - size_w, addr: hold_r.addr + size_w};
        state_nxt = ST_SPLIT_HI;
      end

      ST_SPLIT_HI: begin
        we        = 1'b1;
        waddr     = i_r[IDX_W-1:0];
        wdata     = '{used: 1'b1, size: size_w, addr: hold_r.addr};
        cnt_nxt   = cnt_r + CNT_ONE;
        state_nxt = ST_ALLOC_END;
      end

      // stable insertion sort by address
      ST_SORT_RD: begin
        if (!(i_r < cnt_r)) begin
          if (merge_after_r) begin
            i_nxt     = '0;
            n_nxt     = '0;
            state_nxt = ST_MERGE_RD;
          end else begin
            state_nxt = ST_ALLOC_END;
          end
        end else begin
          raddr     = i_r[IDX_W-1:0];
          state_nxt = ST_SORT_HOLD;
        end
      end

      ST_SORT_HOLD: begin
        hold_nxt  = e;
        j_nxt     = i_r;
        state_nxt = ST_SORT_CRD;
      end

      ST_SORT_CRD: begin
        if (j_r == '0) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = hold_r;
          i_nxt     = i_inc;
          state_nxt = ST_SORT_RD;
        end else begin
          raddr     = j_dec[IDX_W-1:0];
          state_nxt = ST_SORT_CMP;
        end
      end

      ST_SORT_CMP: begin
        we    = 1'b1;
        waddr = j_r[IDX_W-1:0];
        if (e.addr > hold_r.addr) begin
          wdata     = e;
          j_nxt     = j_dec;
          state_nxt = ST_SORT_CRD;
        end else begin
          wdata     = hold_r;
          i_nxt     = i_inc;
          state_nxt = ST_SORT_RD;
        end
      end

      // compaction pass; the open block lives in prev_r until it is closed
      ST_MERGE_RD: begin
        if (i_r == cnt_r) begin
          state_nxt = ST_MERGE_END;
        end else begin
          raddr     = i_r[IDX_W-1:0];
          state_nxt = ST_MERGE_EV;
        end
      end

      ST_MERGE_EV: begin
        if (n_r != '0 && !prev_r.used && !e.used && (prev_r.addr + prev_r.size) == e.addr) begin
          prev_nxt.size = prev_r.size + e.size;
        end else begin
          if (n_r != '0) begin
            we    = 1'b1;
            waddr = n_dec[IDX_W-1:0];
            wdata = prev_r;
          end
          prev_nxt = e;
          n_nxt    = n_r + CNT_ONE;
        end
        i_nxt     = i_inc;
        state_nxt = ST_MERGE_RD;
      end

      ST_MERGE_END: begin
        if (n_r != '0) begin
          we    = 1'b1;
          waddr = n_dec[IDX_W-1:0];
          wdata = prev_r;
        end
        cnt_nxt   = n_r;
        state_nxt = ST_OUT;
      end

      ST_ALLOC_END: begin
        state_nxt = ST_OUT;
        if (realloc_r && result_r != '0 && addr_r != '0) begin
          cbytes_nxt  = cb_w;
          cfrom_nxt   = (cb_w != '0) ? addr_r : '0;
          realloc_nxt = 1'b0;
          mode_nxt    = MD_FREE;
          i_nxt       = '0;
          state_nxt   = ST_FIND_RD;
        end
      end

      ST_OUT: begin
        if (rsp_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (size_done) begin
      if (!realloc_r) begin
        result_nxt = size_val;
        state_nxt  = ST_OUT;
      end else begin
        old_nxt = size_val;
        if (addr_r != '0 && !(amt_r > size_val)) begin
          result_nxt = addr_r;
          state_nxt  = ST_OUT;
        end else if (amt_r > MAX_REQUEST) begin
          result_nxt = '0;
          state_nxt  = ST_ALLOC_END;
        end else begin
          mode_nxt  = MD_ALLOC;
          i_nxt     = '0;
          state_nxt = ST_FIND_RD;
        end
      end
    end

    // heap_start write empties the table and reloads the pointer
    if (cfg.start_wr) begin
      cnt_nxt  = '0;
      bump_nxt = cfg.start_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      bump_r        <= HEAP_START_RST;
      realloc_r     <= 1'b0;
      merge_after_r <= 1'b0;
      mode_r        <= MD_SIZE;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      bump_r        <= bump_nxt;
      realloc_r     <= realloc_nxt;
      merge_after_r <= merge_after_nxt;
      mode_r        <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    amt_r    <= amt_nxt;
    old_r    <= old_nxt;
    result_r <= result_nxt;
    cfrom_r  <= cfrom_nxt;
    cbytes_r <= cbytes_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    n_r      <= n_nxt;
    hold_r   <= hold_nxt;
    prev_r   <= prev_nxt;
  end

endmodule

// ===== rtl/first_fit_block_allocator_core.sv =====
// first_fit_block_allocator_core: first-fit allocator with coalescing, top level
// holds the bump limit register and the output register
// depends on ffba_pkg, ffba_seq (which uses ffba_ram)
//
// usage:
//   in_*  : one operation per transfer, func and mark_used in in_tuser,
//           address and amount in in_tdata
//   out_* : exactly one result per operation (result, copy_from, copy_bytes)
//   cfg_* : write heap_start (index 0) or the bump limit (index 1) while idle;
//           writing heap_start empties the table and reloads the bump pointer
// one operation is in work at a time; in_tready is high while the sequencer
// is idle, also while a finished result still waits in the output register.
// the table ram has one read port and a registered read, so each entry visited
// takes a read state and an evaluate state. the phases of an operation:
//   size / free search, first-fit scan: one walk over the table
//   split: the entries after the chosen block shift up to open a slot
//   insertion sort after bump, free and import: each entry is read and held,
//   then compared against lower entries and moved down until it is in place
//   merge after free and import: one pass over the table
// reset empties the table, loads the pointer with 1 and the limit with 0.
// a stalled receiver holds the result; one further operation may complete
// behind it, after which the sequencer waits.
`timescale 1ns / 1ps

module first_fit_block_allocator_core
  import ffba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // address[31:0], amount[63:32]
  input  logic [3:0]  in_tuser,   // func[2:0], mark_used[3]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // result[31:0], copy_from[63:32], copy_bytes[95:64]

  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] limit_r;
  cfg_t        cfg;
  req_t        req;
  rsp_t        rsp;
  logic        rsp_valid;
  logic        rsp_ready;
  logic        out_valid_r;
  rsp_t        out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= HEAP_TOP_RST;
    end else if (cfg_we && cfg_addr == REG_HEAP_TOP) begin
      limit_r <= cfg_wdata;
    end
  end

  assign cfg.start_wr  = cfg_we && (cfg_addr == REG_HEAP_START);
  assign cfg.start_val = cfg_wdata;
  assign cfg.limit     = limit_r;

  assign req.func      = in_tuser[2:0];
  assign req.mark_used = in_tuser[3];
  assign req.address   = in_tdata[31:0];
  assign req.amount    = in_tdata[63:32];

  ffba_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // output register frees itself in the same cycle it is taken
  assign rsp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_data_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
